FILE: design/event_interest_table_defines.svh
`ifndef EVENT_INTEREST_TABLE_DEFINES_SVH
`define EVENT_INTEREST_TABLE_DEFINES_SVH

// same-cycle implication check, held off during reset
`define EIT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("event interest table check failed");

// next-cycle implication check, held off during reset
`define EIT_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("event interest table check failed");

`endif

FILE: design/eit_pkg.sv
`timescale 1ns / 1ps

package eit_pkg;

  localparam int EIT_NUM_SETS  = 8;
  localparam int EIT_SET_DEPTH = 64;

  localparam int OP_W     = 3;
  localparam int HANDLE_W = 31;
  localparam int FD_W     = 32;
  localparam int MASK_W   = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [HANDLE_W-1:0] HANDLE_START = HANDLE_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 3'd0,
    OP_CLOSE  = 3'd1,
    OP_ADD    = 3'd2,
    OP_DELETE = 3'd3,
    OP_MODIFY = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_NO_SET    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_RANGE     = 3'd5,
    ST_EXHAUSTED = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SSCAN,
    S_EXEC,
    S_ESCAN,
    S_LAST,
    S_APPEND,
    S_RWAIT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    set_step;
    logic    set_take;
    logic    do_create;
    logic    do_close;
    logic    rd_first;
    logic    rd_next;
    logic    rd_index;
    logic    rd_last;
    logic    wr_here;
    logic    wr_append;
    logic    wr_move;
    logic    cap_read;
    logic    set_st;
    status_t st_code;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic hit;
    logic set_match;
    logic set_last;
    logic ctr_zero;
    logic full;
    logic fill_zero;
    logic idx_ok;
    logic fd_match;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

FILE: design/eit_ram.sv
`timescale 1ns / 1ps

module eit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/eit_ctrl.sv
`timescale 1ns / 1ps
`include "event_interest_table_defines.svh"

module eit_ctrl
  import eit_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SSCAN;
      end
      S_SSCAN: begin
        if (sts.set_match || sts.set_last) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (sts.hit) begin
          case (sts.op)
            OP_ADD: begin
              if (!sts.full && !sts.fill_zero) state_next = S_ESCAN;
            end
            OP_DELETE, OP_MODIFY: begin
              if (!sts.fill_zero) state_next = S_ESCAN;
            end
            OP_READ: begin
              if (sts.idx_ok) state_next = S_RWAIT;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ESCAN: begin
        if (sts.fd_match) begin
          state_next = (sts.op == OP_ADD) ? S_DONE : S_LAST;
        end else if (sts.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_LAST: begin
        state_next = (sts.op == OP_MODIFY) ? S_APPEND : S_DONE;
      end
      S_APPEND: state_next = S_DONE;
      S_RWAIT:  state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_SSCAN: begin
        if (sts.set_match) begin
          cmd.set_take = 1'b1;
        end else if (!sts.set_last) begin
          cmd.set_step = 1'b1;
        end
      end
      S_EXEC: begin
        if (!sts.hit) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = (sts.op == OP_CREATE) ? ST_NO_SET : ST_UNKNOWN;
        end else begin
          case (sts.op)
            OP_CREATE: begin
              if (sts.ctr_zero) begin
                cmd.set_st  = 1'b1;
                cmd.st_code = ST_EXHAUSTED;
              end else begin
                cmd.do_create = 1'b1;
              end
            end
            OP_CLOSE: cmd.do_close = 1'b1;
            OP_ADD: begin
              if (sts.full) begin
                cmd.set_st  = 1'b1;
                cmd.st_code = ST_FULL;
              end else if (sts.fill_zero) begin
                cmd.wr_append = 1'b1;
              end else begin
                cmd.rd_first = 1'b1;
              end
            end
            OP_DELETE, OP_MODIFY: begin
              if (sts.fill_zero) begin
                cmd.set_st  = 1'b1;
                cmd.st_code = ST_NOT_FOUND;
              end else begin
                cmd.rd_first = 1'b1;
              end
            end
            OP_READ: begin
              if (sts.idx_ok) begin
                cmd.rd_index = 1'b1;
              end else begin
                cmd.set_st  = 1'b1;
                cmd.st_code = ST_RANGE;
              end
            end
            default: cmd.set_st = 1'b0;
          endcase
        end
      end
      S_ESCAN: begin
        if (sts.fd_match) begin
          if (sts.op == OP_ADD) begin
            cmd.wr_here = 1'b1;
          end else begin
            cmd.rd_last = 1'b1;
          end
        end else if (sts.scan_end) begin
          if (sts.op == OP_ADD) begin
            cmd.wr_append = 1'b1;
          end else begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_NOT_FOUND;
          end
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_LAST:   cmd.wr_move = 1'b1;
      S_APPEND: cmd.wr_append = 1'b1;
      S_RWAIT:  cmd.cap_read = 1'b1;
      S_DONE:   cmd.out_load = sts.out_free;
      default:  cmd.out_load = 1'b0;
    endcase
  end

  `EIT_ASSERT_IMP(a_store_needs_set, clk, rst, cmd.wr_here || cmd.wr_append || cmd.wr_move, sts.hit)
  `EIT_ASSERT_NXT(a_accept_starts, clk, rst, (state == S_IDLE) && in_valid, state == S_SSCAN)
  `EIT_ASSERT_IMP(a_load_when_free, clk, rst, cmd.out_load, sts.out_free)

endmodule

FILE: design/eit_dpath.sv
`timescale 1ns / 1ps
`include "event_interest_table_defines.svh"

module eit_dpath
  import eit_pkg::*;
#(
  parameter int NUM_SETS  = EIT_NUM_SETS,
  parameter int SET_DEPTH = EIT_SET_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic [OP_W-1:0]            op,
  input  logic [HANDLE_W-1:0]        set_handle,
  input  logic signed [FD_W-1:0]     fd,
  input  logic [MASK_W-1:0]          event_mask,
  input  logic [INDEX_W-1:0]         entry_index,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        status,
  output logic [HANDLE_W-1:0]        new_handle,
  output logic [COUNT_W-1:0]         entry_count,
  output logic signed [FD_W-1:0]     read_fd,
  output logic [MASK_W-1:0]          read_mask
);

  localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int FILL_W    = $clog2(SET_DEPTH + 1);
  localparam int CMP_W     = (FILL_W > INDEX_W) ? FILL_W : INDEX_W;
  localparam int ADDR_W    = SET_W + IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int WORD_W    = FD_W + MASK_W;

  // latched item
  op_t                 op_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [FD_W-1:0]     fd_r;
  logic [MASK_W-1:0]   mask_r;
  logic [INDEX_W-1:0]  idx_r;

  // set table
  logic [NUM_SETS-1:0] used;
  logic [HANDLE_W-1:0] set_id [NUM_SETS];
  logic [FILL_W-1:0]   fill [NUM_SETS];
  logic [HANDLE_W-1:0] handle_ctr;
  logic [HANDLE_W-1:0] ctr_inc;

  // walk state
  logic [SET_W-1:0]    set_idx;
  logic                hit;
  logic [FILL_W-1:0]   ent;
  logic [IDX_W-1:0]    pos;
  status_t             st_r;
  logic [HANDLE_W-1:0] nh_r;
  logic [FD_W-1:0]     rfd_r;
  logic [MASK_W-1:0]   rmask_r;

  logic [FILL_W-1:0]   fill_cur;
  logic [FILL_W-1:0]   fill_last;
  logic [FILL_W-1:0]   ent_prev;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_slot;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_slot;
  logic [WORD_W-1:0]   wr_word;
  logic [WORD_W-1:0]   q;

  assign fill_cur  = fill[set_idx];
  assign fill_last = FILL_W'(fill_cur - 1'b1);
  assign ent_prev  = FILL_W'(ent - 1'b1);
  assign ctr_inc   = HANDLE_W'(handle_ctr + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r     <= op_t'(op);
      handle_r <= set_handle;
      fd_r     <= fd;
      mask_r   <= event_mask;
      idx_r    <= entry_index;
      nh_r     <= '0;
      rfd_r    <= '0;
      rmask_r  <= '0;
    end
    if (cmd.do_create) begin
      set_id[set_idx] <= handle_ctr;
      nh_r            <= handle_ctr;
    end
    if (cmd.rd_first) begin
      ent <= FILL_W'(1);
    end else if (cmd.rd_next) begin
      ent <= FILL_W'(ent + 1'b1);
    end
    if (cmd.rd_last) begin
      pos <= ent_prev[IDX_W-1:0];
    end
    if (cmd.cap_read) begin
      rfd_r   <= q[WORD_W-1:MASK_W];
      rmask_r <= q[MASK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      fill       <= '{default: '0};
      handle_ctr <= HANDLE_START;
      set_idx    <= '0;
      hit        <= 1'b0;
      st_r       <= ST_OK;
    end else begin
      if (cmd.load_item) begin
        set_idx <= '0;
        hit     <= 1'b0;
        st_r    <= ST_OK;
      end
      if (cmd.set_step) set_idx <= SET_W'(set_idx + 1'b1);
      if (cmd.set_take) hit <= 1'b1;
      if (cmd.set_st) st_r <= cmd.st_code;
      if (cmd.do_create) begin
        used[set_idx] <= 1'b1;
        fill[set_idx] <= '0;
        handle_ctr    <= ctr_inc;
      end
      if (cmd.do_close) begin
        used[set_idx] <= 1'b0;
        fill[set_idx] <= '0;
      end
      if (cmd.wr_append) fill[set_idx] <= FILL_W'(fill_cur + 1'b1);
      if (cmd.wr_move) fill[set_idx] <= fill_last;
    end
  end

  // slot store port muxing
  always_comb begin
    rd_en   = cmd.rd_first | cmd.rd_next | cmd.rd_index | cmd.rd_last;
    rd_slot = '0;
    if (cmd.rd_next) begin
      rd_slot = ent[IDX_W-1:0];
    end else if (cmd.rd_index) begin
      rd_slot = IDX_W'(idx_r);
    end else if (cmd.rd_last) begin
      rd_slot = fill_last[IDX_W-1:0];
    end
    wr_en   = cmd.wr_here | cmd.wr_append | cmd.wr_move;
    wr_slot = pos;
    wr_word = {fd_r, mask_r};
    if (cmd.wr_here) begin
      wr_slot = ent_prev[IDX_W-1:0];
    end else if (cmd.wr_append) begin
      wr_slot = fill_cur[IDX_W-1:0];
    end else if (cmd.wr_move) begin
      wr_word = q;
    end
  end

  eit_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({set_idx, wr_slot}),
    .wdata (wr_word),
    .re    (rd_en),
    .raddr ({set_idx, rd_slot}),
    .rdata (q)
  );

  always_comb begin
    sts.op        = op_r;
    sts.hit       = hit;
    sts.set_match = (op_r == OP_CREATE) ? !used[set_idx]
                                        : (used[set_idx] && (set_id[set_idx] == handle_r));
    sts.set_last  = (set_idx == SET_W'(NUM_SETS - 1));
    sts.ctr_zero  = (handle_ctr == '0);
    sts.full      = (fill_cur == FILL_W'(SET_DEPTH));
    sts.fill_zero = (fill_cur == '0);
    sts.idx_ok    = (CMP_W'(idx_r) < CMP_W'(fill_cur));
    sts.fd_match  = (q[WORD_W-1:MASK_W] == fd_r);
    sts.scan_end  = (ent == fill_cur);
    sts.out_free  = !out_valid || out_ready;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= st_r;
      new_handle  <= nh_r;
      entry_count <= hit ? COUNT_W'(fill_cur) : '0;
      read_fd     <= rfd_r;
      read_mask   <= rmask_r;
    end
  end

  `EIT_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill_cur <= FILL_W'(SET_DEPTH))
  `EIT_ASSERT_NXT(a_handle_advance, clk, rst, cmd.do_create, handle_ctr == $past(ctr_inc))
  `EIT_ASSERT_IMP(a_read_in_range, clk, rst, cmd.rd_index, sts.idx_ok)

endmodule

FILE: design/event_interest_table.sv
`timescale 1ns / 1ps
// channel  handshake              payload
// in       in_valid / in_ready    op, set_handle, fd, event_mask, entry_index
// out      out_valid / out_ready  status, new_handle, entry_count, read_fd, read_mask
//
// one item at a time: set lookup walks the sets one per cycle, then add, delete and
// modify walk the set's entries at one slot store read per cycle
// synchronous reset empties all sets and restarts handles at 3; no clearing pass
// in_ready is high only between items; a finished beat waits in the output register
// while the next item is accepted, and the block holds before loading a new result

module event_interest_table
  import eit_pkg::*;
#(
  parameter int NUM_SETS  = EIT_NUM_SETS,
  parameter int SET_DEPTH = EIT_SET_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OP_W-1:0]        op,
  input  logic [HANDLE_W-1:0]    set_handle,
  input  logic signed [FD_W-1:0] fd,
  input  logic [MASK_W-1:0]      event_mask,
  input  logic [INDEX_W-1:0]     entry_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [HANDLE_W-1:0]    new_handle,
  output logic [COUNT_W-1:0]     entry_count,
  output logic signed [FD_W-1:0] read_fd,
  output logic [MASK_W-1:0]      read_mask
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: set walk, dispatch, entry walk, move/append, read capture, result hand-off
  eit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: set table, handle counter, slot store, result register
  eit_dpath #(
    .NUM_SETS  (NUM_SETS),
    .SET_DEPTH (SET_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .set_handle  (set_handle),
    .fd          (fd),
    .event_mask  (event_mask),
    .entry_index (entry_index),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .new_handle  (new_handle),
    .entry_count (entry_count),
    .read_fd     (read_fd),
    .read_mask   (read_mask)
  );

endmodule

FILE: tb/event_interest_table_tb.sv
`timescale 1ns / 1ps

module event_interest_table_tb
  import eit_pkg::*;
();

  localparam int NUM_SETS  = EIT_NUM_SETS;
  localparam int SET_DEPTH = EIT_SET_DEPTH;

  // op codes the block has no use for; they must pass through as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int BURST_LEN      = 74;    // enough adds to overflow an empty set
  localparam int LONG_HOLD      = 500;   // receiver back-pressure stretch
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either side

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic [FD_W-1:0]     fd;
    logic [MASK_W-1:0]   mask;
    logic [INDEX_W-1:0]  idx;
  } op_item_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] new_handle;
    logic [COUNT_W-1:0]  count;
    logic [FD_W-1:0]     rfd;
    logic [MASK_W-1:0]   rmask;
  } op_result_t;

  // directed row: typed rows carry an expectation read straight off the spec
  typedef struct packed {
    op_item_t   it;
    logic       typed;
    op_result_t res;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OP_W-1:0]        op = '0;
  logic [HANDLE_W-1:0]    set_handle = '0;
  logic signed [FD_W-1:0] fd = '0;
  logic [MASK_W-1:0]      event_mask = '0;
  logic [INDEX_W-1:0]     entry_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [HANDLE_W-1:0]    new_handle;
  logic [COUNT_W-1:0]     entry_count;
  logic signed [FD_W-1:0] read_fd;
  logic [MASK_W-1:0]      read_mask;

  always #2 clk = ~clk;

  event_interest_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .set_handle (set_handle),
    .fd         (fd),
    .event_mask (event_mask),
    .entry_index(entry_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .new_handle (new_handle),
    .entry_count(entry_count),
    .read_fd    (read_fd),
    .read_mask  (read_mask)
  );

  // ---------------------------------------------------------------------------
  // shadow copy of the interest table, stepped once per accepted input beat
  // ---------------------------------------------------------------------------
  logic                tbl_used [NUM_SETS];
  logic [HANDLE_W-1:0] tbl_id   [NUM_SETS];
  logic [COUNT_W-1:0]  tbl_fill [NUM_SETS];
  logic [FD_W-1:0]     tbl_fd   [NUM_SETS][SET_DEPTH];
  logic [MASK_W-1:0]   tbl_mask [NUM_SETS][SET_DEPTH];
  logic [HANDLE_W-1:0] model_handle;

  op_result_t pending_results[$];
  directed_row_t directed_rows[$];

  int mismatches     = 0;
  int items_sent     = 0;
  int beats_checked  = 0;
  int status_seen[8] = '{default: 0};
  int rx_stall_left  = 0;
  int rx_gap         = 0;
  int long_holds     = 0;
  int idle_cycles    = 0;

  // add or replace; a full set refuses even a descriptor it already holds
  function automatic status_t put_entry(int s, logic [FD_W-1:0] f, logic [MASK_W-1:0] m);
    if (tbl_fill[s] >= SET_DEPTH) return ST_FULL;
    for (int i = 0; i < tbl_fill[s]; i++) begin
      if (tbl_fd[s][i] == f) begin
        tbl_mask[s][i] = m;
        return ST_OK;
      end
    end
    tbl_fd[s][tbl_fill[s]]   = f;
    tbl_mask[s][tbl_fill[s]] = m;
    tbl_fill[s]++;
    return ST_OK;
  endfunction

  // remove by moving the last entry into the hole
  function automatic status_t drop_entry(int s, logic [FD_W-1:0] f);
    int last;
    for (int i = 0; i < tbl_fill[s]; i++) begin
      if (tbl_fd[s][i] == f) begin
        last = tbl_fill[s] - 1;
        tbl_fd[s][i]   = tbl_fd[s][last];
        tbl_mask[s][i] = tbl_mask[s][last];
        tbl_fill[s]--;
        return ST_OK;
      end
    end
    return ST_NOT_FOUND;
  endfunction

  function automatic op_result_t apply_table_op(op_item_t it);
    op_result_t r;
    int s;
    r = '0;
    r.status = ST_OK;
    s = -1;
    if (it.op == OP_CREATE) begin
      for (int i = NUM_SETS - 1; i >= 0; i--) if (!tbl_used[i]) s = i;
      if (s < 0) begin
        r.status = ST_NO_SET;
      end else if (model_handle == '0) begin
        r.status = ST_EXHAUSTED;
      end else begin
        tbl_used[s] = 1'b1;
        tbl_fill[s] = '0;
        tbl_id[s]   = model_handle;
        r.new_handle = model_handle;
        model_handle++;
      end
    end else begin
      for (int i = NUM_SETS - 1; i >= 0; i--) begin
        if (tbl_used[i] && tbl_id[i] == it.handle) s = i;
      end
      if (s < 0) begin
        r.status = ST_UNKNOWN;
      end else begin
        case (it.op)
          OP_CLOSE: begin
            tbl_used[s] = 1'b0;
            tbl_fill[s] = '0;
          end
          OP_ADD:    r.status = put_entry(s, it.fd, it.mask);
          OP_DELETE: r.status = drop_entry(s, it.fd);
          OP_MODIFY: begin
            r.status = drop_entry(s, it.fd);
            if (r.status == ST_OK) r.status = put_entry(s, it.fd, it.mask);
          end
          OP_READ: begin
            if (it.idx < tbl_fill[s]) begin
              r.rfd   = tbl_fd[s][it.idx];
              r.rmask = tbl_mask[s][it.idx];
            end else begin
              r.status = ST_RANGE;
            end
          end
          default: ;
        endcase
        r.count = tbl_fill[s];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly back-to-back, sometimes a short gap, now and then a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(12, 40);
  endfunction

  function automatic int pick_live_set();
    int live[$];
    for (int i = 0; i < NUM_SETS; i++) if (tbl_used[i]) live.push_back(i);
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  // pick an existing entry of set s when it has one, else a fresh word
  function automatic logic [FD_W-1:0] present_fd(int s);
    if (tbl_fill[s] == 0) return $urandom();
    return tbl_fd[s][$urandom_range(0, tbl_fill[s] - 1)];
  endfunction

  // well-formed traffic on live handles, with a sprinkling of stray handles
  function automatic op_item_t random_item();
    op_item_t it;
    int s;
    int r;
    it.op     = OP_CREATE;
    it.handle = HANDLE_W'($urandom());
    it.fd     = $urandom();
    it.mask   = ($urandom_range(0, 9) == 0) ? '0 : MASK_W'($urandom());
    it.idx    = INDEX_W'($urandom_range(0, 63));
    s = pick_live_set();
    r = $urandom_range(0, 99);
    if (s < 0 || r < 6) return it;
    if ($urandom_range(0, 19) != 0) it.handle = tbl_id[s];
    // small descriptor pool and present entries so adds replace and deletes hit
    case ($urandom_range(0, 3))
      0, 1: it.fd = present_fd(s);
      2:    it.fd = FD_W'($urandom_range(0, 31));
      default: ;
    endcase
    if (r < 11) it.op = OP_CLOSE;
    else if (r < 46) it.op = OP_ADD;
    else if (r < 60) it.op = OP_DELETE;
    else if (r < 74) it.op = OP_MODIFY;
    else if (r < 96) begin
      it.op = OP_READ;
      if (tbl_fill[s] > 0 && $urandom_range(0, 4) != 0) begin
        it.idx = INDEX_W'($urandom_range(0, tbl_fill[s] - 1));
      end
    end else begin
      it.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    end
    return it;
  endfunction

  // drive one beat; after a gap or a drain, valid drops before it rises again
  task automatic send_item(input op_item_t it, input int gap, input bit drain,
                           input bit typed, input op_result_t typed_res);
    op_result_t predicted;
    if (gap > 0 || drain) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (pending_results.size() != 0);
      end
    end
    in_valid    <= 1'b1;
    op          <= it.op;
    set_handle  <= it.handle;
    fd          <= it.fd;
    event_mask  <= it.mask;
    entry_index <= it.idx;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge; the shadow table always steps, typed rows
    // replace only the expectation
    predicted = apply_table_op(it);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] o, input logic [HANDLE_W-1:0] h,
                         input logic [FD_W-1:0] f, input logic [MASK_W-1:0] m,
                         input logic [INDEX_W-1:0] ix, input bit typed, input status_t st,
                         input logic [HANDLE_W-1:0] nh, input logic [COUNT_W-1:0] cnt);
    directed_row_t row;
    row = '0;
    row.it.op     = o;
    row.it.handle = h;
    row.it.fd     = f;
    row.it.mask   = m;
    row.it.idx    = ix;
    row.typed     = typed;
    row.res.status     = st;
    row.res.new_handle = nh;
    row.res.count      = cnt;
    directed_rows.push_back(row);
  endtask

  function automatic void report_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, exp_v, act_v);
    mismatches++;
  endfunction

  task automatic check_beat();
    op_result_t exp_r;
    status_seen[status]++;
    beats_checked++;
    if (pending_results.size() == 0) begin
      $display("%0t: output beat with nothing expected, status %0d", $time, status);
      mismatches++;
    end else begin
      exp_r = pending_results.pop_front();
      if (status !== exp_r.status)
        report_field("status", 64'(exp_r.status), 64'(status));
      if (new_handle !== exp_r.new_handle)
        report_field("new_handle", 64'(exp_r.new_handle), 64'(new_handle));
      if (entry_count !== exp_r.count)
        report_field("entry_count", 64'(exp_r.count), 64'(entry_count));
      if (read_fd !== exp_r.rfd)
        report_field("read_fd", 64'(exp_r.rfd), 64'(unsigned'(read_fd)));
      if (read_mask !== exp_r.rmask)
        report_field("read_mask", 64'(exp_r.rmask), 64'(read_mask));
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: check every beat, idle ready at random, with calm stretches
  // and two long holds so the block backs up into in_ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_beat();
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end else if (long_holds < 2 && beats_checked >= 600 + 800 * long_holds) begin
        long_holds++;
        rx_stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if ((beats_checked % 500) < 100) begin
        out_ready <= 1'b1;
      end else begin
        rx_gap = pick_gap();
        if (rx_gap > 0) begin
          rx_stall_left = rx_gap - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // watchdog: any stretch without a beat on either channel beyond the limit
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, giving up", $time, idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    op_item_t it;
    int n;
    int s;
    int gap;

    for (int i = 0; i < NUM_SETS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_id[i]   = '0;
      tbl_fill[i] = '0;
    end
    model_handle = HANDLE_START;

    // directed table; handles run 3, 4, ... in order of creation.
    // handle exhaustion needs about 2^31 creates and is out of reach here
    add_row(OP_CREATE,   31'd0,          32'd0,          32'd0,          6'd0,  1'b1, ST_OK,
            31'd3, 7'd0);
    add_row(OP_CLOSE,    31'd0,          32'd0,          32'd0,          6'd0,  1'b1, ST_UNKNOWN,
            31'd0, 7'd0);
    // most negative and most positive descriptors, all-ones and zero masks
    add_row(OP_ADD,      31'd3,          32'h8000_0000,  32'hffff_ffff,  6'd0,  1'b1, ST_OK,
            31'd0, 7'd1);
    add_row(OP_ADD,      31'd3,          32'h7fff_ffff,  32'd0,          6'd0,  1'b1, ST_OK,
            31'd0, 7'd2);
    // add of a present descriptor replaces its mask
    add_row(OP_ADD,      31'd3,          32'h8000_0000,  32'h0000_0005,  6'd0,  1'b0, ST_OK,
            31'd0, 7'd0);
    add_row(OP_READ,     31'd3,          32'd0,          32'd0,          6'd0,  1'b0, ST_OK,
            31'd0, 7'd0);
    add_row(OP_READ,     31'd3,          32'd0,          32'd0,          6'd63, 1'b1, ST_RANGE,
            31'd0, 7'd2);
    add_row(OP_DELETE,   31'd3,          32'd1,          32'd0,          6'd0,  1'b1, ST_NOT_FOUND,
            31'd0, 7'd2);
    // modify moves the entry to the end
    add_row(OP_MODIFY,   31'd3,          32'h8000_0000,  32'h0000_000a,  6'd0,  1'b0, ST_OK,
            31'd0, 7'd0);
    add_row(OP_MODIFY,   31'd3,          32'd99,         32'h1234_5678,  6'd0,  1'b1, ST_NOT_FOUND,
            31'd0, 7'd2);
    add_row(OP_DELETE,   31'd3,          32'h7fff_ffff,  32'd0,          6'd0,  1'b0, ST_OK,
            31'd0, 7'd0);
    add_row(OP_READ,     31'd3,          32'd0,          32'd0,          6'd0,  1'b0, ST_OK,
            31'd0, 7'd0);
    add_row(OP_SPARE_LO, 31'd3,          32'd0,          32'd0,          6'd0,  1'b0, ST_OK,
            31'd0, 7'd0);
    add_row(OP_SPARE_HI, 31'h7fff_ffff,  32'hffff_ffff,  32'hffff_ffff,  6'd63, 1'b1, ST_UNKNOWN,
            31'd0, 7'd0);
    // fill the pool, then one create too many
    for (int i = 0; i < NUM_SETS - 1; i++) begin
      add_row(OP_CREATE, 31'd0,          32'd0,          32'd0,          6'd0,  1'b0, ST_OK,
              31'd0, 7'd0);
    end
    add_row(OP_CREATE,   31'd0,          32'd0,          32'd0,          6'd0,  1'b1, ST_NO_SET,
            31'd0, 7'd0);
    add_row(OP_CLOSE,    31'd3,          32'd0,          32'd0,          6'd0,  1'b1, ST_OK,
            31'd0, 7'd0);
    add_row(OP_CREATE,   31'd0,          32'd0,          32'd0,          6'd0,  1'b0, ST_OK,
            31'd0, 7'd0);
    add_row(OP_READ,     31'd3,          32'd0,          32'd0,          6'd0,  1'b1, ST_UNKNOWN,
            31'd0, 7'd0);
    add_row(OP_READ,     31'd11,         32'd0,          32'd0,          6'd0,  1'b1, ST_RANGE,
            31'd0, 7'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].it, pick_gap(), 1'b0, directed_rows[i].typed,
                directed_rows[i].res);
    end

    // random phase: mostly well-formed traffic on live sets, a burst now and
    // then that drives one set past full, and a full drain every 450 items
    n = 0;
    while (n < RANDOM_ITEMS) begin
      gap = ((n % 400) < 80) ? 0 : pick_gap();
      s = pick_live_set();
      if (n % 300 == 150 && s >= 0) begin
        for (int k = 0; k < BURST_LEN; k++) begin
          it.op     = OP_ADD;
          it.handle = tbl_id[s];
          it.fd     = $urandom();
          it.mask   = $urandom();
          it.idx    = INDEX_W'($urandom_range(0, 63));
          if (k == 66) begin
            it.fd = present_fd(s);       // present descriptor on a full set
          end else if (k == 67 || k == 68) begin
            it.op = OP_MODIFY;
            it.fd = present_fd(s);
          end else if (k >= 69 && k < 73) begin
            it.op = OP_READ;
            if (k == 69) it.idx = INDEX_W'(SET_DEPTH - 1);
          end else if (k == 73) begin
            it.op = OP_DELETE;
            it.fd = present_fd(s);
          end
          send_item(it, ((n % 400) < 80) ? 0 : pick_gap(), 1'b0, 1'b0, '0);
          n++;
        end
      end else begin
        send_item(random_item(), gap, n % 450 == 449, 1'b0, '0);
        n++;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations, %0d result beats checked, %0d mismatches",
             items_sent, beats_checked, mismatches);
    $display("statuses seen: ok %0d, unknown set %0d, no free set %0d, set full %0d, %s %0d, %s %0d",
             status_seen[ST_OK], status_seen[ST_UNKNOWN], status_seen[ST_NO_SET],
             status_seen[ST_FULL], "fd not found", status_seen[ST_NOT_FOUND],
             "index out of range", status_seen[ST_RANGE]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
